@@ sv/aet_pkg.sv @@
// Shared types and constants for the arithmetic expression tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package aet_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 16;
   localparam int RESULT_DEPTH_DEFAULT   = 4;

   localparam int KIND_WIDTH   = 4;
   localparam int OUT_POS_W    = 16;
   localparam int LENGTH_W     = 16;
   localparam int VALUE_W      = 31;
   localparam int CHAR_W       = 8;

   localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;
   localparam logic [VALUE_W-1:0]  VALUE_MAX  = '1;

   localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_OPEN   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE  = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_NUMBER  = 4'd0,
      KIND_SPACE   = 4'd1,
      KIND_PLUS    = 4'd2,
      KIND_MINUS   = 4'd3,
      KIND_STAR    = 4'd4,
      KIND_SLASH   = 4'd5,
      KIND_OPEN    = 4'd6,
      KIND_CLOSE   = 4'd7,
      KIND_INVALID = 4'd8,
      KIND_END     = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_DIGIT = 2'd1,
      CLASS_WS    = 2'd2
   } run_class_type;

   typedef struct packed {
      kind_type              kind;
      logic [OUT_POS_W-1:0]  start;
      logic [LENGTH_W-1:0]   length;
      logic [VALUE_W-1:0]    value;
      logic                  overflow;
      logic [CHAR_W-1:0]     ch;
      logic                  last;
   } token_type;

endpackage

`default_nettype wire

@@ sv/arith_expression_tokenizer.sv @@
// Arithmetic expression tokenizer: byte stream in, tokens out.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_type, req_text_byte
//   rsp      out        rsp_valid/rsp_ready   token fields, rsp_last_of_run
//
// One item per cycle unless stalled: classification and times-ten accumulate sit
// between the run state registers and a four-entry result queue, where an accepted
// item's tokens are registered before they show on rsp. An item yields at most two
// tokens and the queue drains one per cycle; it takes an item while it has room for
// two, so input stalls when rsp_ready is low or two-token items outrun the drain.
// Synchronous active-high reset clears the run state, position and queue.
`timescale 1ns / 1ps
`default_nettype none

module arith_expression_tokenizer
   import aet_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_type,
   input  wire logic [CHAR_W-1:0]     req_text_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [KIND_WIDTH-1:0]      rsp_token_kind,
   output logic [OUT_POS_W-1:0]       rsp_start_position,
   output logic [LENGTH_W-1:0]        rsp_token_length,
   output logic [VALUE_W-1:0]         rsp_number_value,
   output logic                       rsp_value_overflow,
   output logic [CHAR_W-1:0]          rsp_token_char,
   output logic                       rsp_last_of_run
);

   localparam int RESULT_DEPTH = RESULT_DEPTH_DEFAULT;
   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(RESULT_DEPTH - 2);

   // run state
   run_class_type              run_class_ff, run_class_in;
   logic [POSITION_WIDTH-1:0]  run_start_ff, run_start_in;
   logic [LENGTH_W-1:0]        run_length_ff, run_length_in;
   logic [VALUE_W-1:0]         acc_ff, acc_in;
   logic                       ovf_ff, ovf_in;
   logic [POSITION_WIDTH-1:0]  pos_ff, pos_in;

   // result queue
   token_type                  queue_ff [RESULT_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   logic                       accept, pop;
   run_class_type              cls;
   logic                       extend, close_tok, second_tok;
   token_type                  run_tok, sec_tok, tok_a, tok_b;
   logic [1:0]                 push_n;
   logic [VALUE_W-1:0]         digit_acc;
   logic                       digit_ovf;
   logic [VALUE_W+3:0]         times_ten;
   logic [3:0]                 digit;
   logic [31:0]                run_start_wide, pos_wide;
   kind_type                   op_kind;
   logic [PTR_W-1:0]           wr_next;

   assign req_ready = (count_ff <= ROOM_LIMIT);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign run_start_wide = 32'(run_start_ff);
   assign pos_wide       = 32'(pos_ff);

   always_comb begin
      if ((req_text_byte >= CHAR_ZERO) && (req_text_byte <= CHAR_NINE)) begin
         cls = CLASS_DIGIT;
      end else if ((req_text_byte == CHAR_SPACE) ||
                   ((req_text_byte >= CHAR_TAB) && (req_text_byte <= CHAR_CR))) begin
         cls = CLASS_WS;
      end else begin
         cls = CLASS_NONE;
      end
   end

   always_comb begin
      unique case (req_text_byte)
         CHAR_PLUS:  op_kind = KIND_PLUS;
         CHAR_MINUS: op_kind = KIND_MINUS;
         CHAR_STAR:  op_kind = KIND_STAR;
         CHAR_SLASH: op_kind = KIND_SLASH;
         CHAR_OPEN:  op_kind = KIND_OPEN;
         CHAR_CLOSE: op_kind = KIND_CLOSE;
         default:    op_kind = KIND_INVALID;
      endcase
   end

   assign extend     = !req_type && (cls != CLASS_NONE) && (cls == run_class_ff);
   assign close_tok  = !extend && (run_class_ff != CLASS_NONE);
   assign second_tok = req_type || (cls == CLASS_NONE);

   // value*10 + digit, saturating; a fresh run starts from zero
   assign digit     = 4'(req_text_byte - CHAR_ZERO);
   assign times_ten = ({4'b0, (extend ? acc_ff : '0)} << 3)
                    + ({4'b0, (extend ? acc_ff : '0)} << 1)
                    + (VALUE_W+4)'(digit);
   always_comb begin
      if (times_ten > (VALUE_W+4)'(VALUE_MAX)) begin
         digit_acc = VALUE_MAX;
         digit_ovf = 1'b1;
      end else begin
         digit_acc = times_ten[VALUE_W-1:0];
         digit_ovf = extend && ovf_ff;
      end
   end

   always_comb begin
      run_tok.kind     = (run_class_ff == CLASS_DIGIT) ? KIND_NUMBER : KIND_SPACE;
      run_tok.start    = run_start_wide[OUT_POS_W-1:0];
      run_tok.length   = run_length_ff;
      run_tok.value    = (run_class_ff == CLASS_DIGIT) ? acc_ff : '0;
      run_tok.overflow = (run_class_ff == CLASS_DIGIT) && ovf_ff;
      run_tok.ch       = '0;
      run_tok.last     = !second_tok;

      sec_tok.kind     = req_type ? KIND_END : op_kind;
      sec_tok.start    = pos_wide[OUT_POS_W-1:0];
      sec_tok.length   = req_type ? '0 : LENGTH_W'(1);
      sec_tok.value    = '0;
      sec_tok.overflow = 1'b0;
      sec_tok.ch       = req_type ? '0 : req_text_byte;
      sec_tok.last     = 1'b1;

      tok_a  = close_tok ? run_tok : sec_tok;
      tok_b  = sec_tok;
      push_n = accept ? (2'(close_tok) + 2'(second_tok)) : 2'd0;
   end

   always_comb begin
      run_class_in  = run_class_ff;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      if (accept) begin
         if (req_type) begin
            run_class_in  = CLASS_NONE;
            run_start_in  = '0;
            run_length_in = '0;
            acc_in        = '0;
            ovf_in        = 1'b0;
            pos_in        = '0;
         end else begin
            if (extend) begin
               if (run_length_ff != LENGTH_MAX) begin
                  run_length_in = run_length_ff + LENGTH_W'(1);
               end
            end else if (cls != CLASS_NONE) begin
               run_class_in  = cls;
               run_start_in  = pos_ff;
               run_length_in = LENGTH_W'(1);
               acc_in        = '0;
               ovf_in        = 1'b0;
            end else begin
               run_class_in  = CLASS_NONE;
               run_length_in = '0;
               acc_in        = '0;
               ovf_in        = 1'b0;
            end
            if (cls == CLASS_DIGIT) begin
               acc_in = digit_acc;
               ovf_in = digit_ovf;
            end
            pos_in = pos_ff + POSITION_WIDTH'(1);
         end
      end
   end

   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff  <= CLASS_NONE;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         pos_ff        <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         run_class_ff  <= run_class_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         pos_ff        <= pos_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= tok_a;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_next] <= tok_b;
      end
   end

   assign rsp_token_kind     = queue_ff[rd_ptr_ff].kind;
   assign rsp_start_position = queue_ff[rd_ptr_ff].start;
   assign rsp_token_length   = queue_ff[rd_ptr_ff].length;
   assign rsp_number_value   = queue_ff[rd_ptr_ff].value;
   assign rsp_value_overflow = queue_ff[rd_ptr_ff].overflow;
   assign rsp_token_char     = queue_ff[rd_ptr_ff].ch;
   assign rsp_last_of_run    = queue_ff[rd_ptr_ff].last;

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RESULT_DEPTH))
      else $error("result queue overflow");

   // an open run always has a nonzero length, a closed one none
   assert property (@(posedge clock) disable iff (reset)
      (run_class_ff == CLASS_NONE) == (run_length_ff == '0))
      else $error("run length out of step with run class");

   // end of text restarts the position count
   assert property (@(posedge clock) disable iff (reset)
      accept && req_type |=> (pos_ff == '0) && (run_class_ff == CLASS_NONE))
      else $error("end of text did not restart the text");

   // queue occupancy follows pushes and pops
   assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd0) && !pop |=> $stable(count_ff))
      else $error("queue count moved without traffic");

endmodule

`default_nettype wire

@@ tb/sv/aet_token_checker.sv @@
// Token scoreboard: predicts the tokens of each accepted byte and checks the tokenizer's output.
`timescale 1ns / 1ps

module aet_token_checker
   import aet_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic                  req_type,
   input  wire logic [CHAR_W-1:0]     req_text_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [KIND_WIDTH-1:0] rsp_token_kind,
   input  wire logic [OUT_POS_W-1:0]  rsp_start_position,
   input  wire logic [LENGTH_W-1:0]   rsp_token_length,
   input  wire logic [VALUE_W-1:0]    rsp_number_value,
   input  wire logic                  rsp_value_overflow,
   input  wire logic [CHAR_W-1:0]     rsp_token_char,
   input  wire logic                  rsp_last_of_run,
   output int                         fail_count,
   output int                         pending
);

   // tokenizer state as the scoreboard sees it; position width is the default 16
   run_class_type        run_class;
   logic [OUT_POS_W-1:0] run_start;
   logic [LENGTH_W-1:0]  run_length;
   logic [VALUE_W-1:0]   number_acc;
   logic                 number_ovf;
   logic [OUT_POS_W-1:0] byte_pos;

   token_type expected_tokens[$];
   token_type item_tokens[$];
   int        mismatches     = 0;
   int        tokens_checked = 0;
   int        queued         = 0;

   assign fail_count = mismatches;
   assign pending    = queued;

   task automatic report_mismatch(input string msg);
      $display("%0t checker: %s", $time, msg);
      mismatches++;
   endtask

   function automatic token_type make_token(input kind_type kind,
                                            input logic [OUT_POS_W-1:0] start,
                                            input logic [LENGTH_W-1:0] len,
                                            input logic [VALUE_W-1:0] value,
                                            input logic ovf,
                                            input logic [CHAR_W-1:0] ch);
      token_type t;
      t.kind     = kind;
      t.start    = start;
      t.length   = len;
      t.value    = value;
      t.overflow = ovf;
      t.ch       = ch;
      t.last     = 1'b0;
      return t;
   endfunction

   function automatic run_class_type classify(input logic [CHAR_W-1:0] b);
      if (b >= CHAR_ZERO && b <= CHAR_NINE)
         return CLASS_DIGIT;
      if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))
         return CLASS_WS;
      return CLASS_NONE;
   endfunction

   function automatic kind_type operator_kind(input logic [CHAR_W-1:0] b);
      case (b)
         CHAR_PLUS:  return KIND_PLUS;
         CHAR_MINUS: return KIND_MINUS;
         CHAR_STAR:  return KIND_STAR;
         CHAR_SLASH: return KIND_SLASH;
         CHAR_OPEN:  return KIND_OPEN;
         CHAR_CLOSE: return KIND_CLOSE;
         default:    return KIND_INVALID;
      endcase
   endfunction

   task automatic close_open_run();
      if (run_class == CLASS_DIGIT)
         item_tokens.push_back(make_token(KIND_NUMBER, run_start, run_length, number_acc,
                                          number_ovf, '0));
      else if (run_class == CLASS_WS)
         item_tokens.push_back(make_token(KIND_SPACE, run_start, run_length, '0, 1'b0, '0));
      run_class  = CLASS_NONE;
      run_length = '0;
      number_acc = '0;
      number_ovf = 1'b0;
   endtask

   task automatic tokenize_item(input logic is_end, input logic [CHAR_W-1:0] b);
      run_class_type      cls;
      token_type          tail;
      logic [VALUE_W+3:0] grown;
      item_tokens.delete();
      if (is_end) begin
         close_open_run();
         item_tokens.push_back(make_token(KIND_END, byte_pos, '0, '0, 1'b0, '0));
         byte_pos  = '0;
         run_start = '0;
      end else begin
         cls = classify(b);
         if (cls != CLASS_NONE && cls == run_class) begin
            if (run_length != LENGTH_MAX)
               run_length = run_length + 1'b1;
         end else begin
            close_open_run();
            if (cls != CLASS_NONE) begin
               run_class  = cls;
               run_start  = byte_pos;
               run_length = LENGTH_W'(1);
            end else begin
               item_tokens.push_back(make_token(operator_kind(b), byte_pos, LENGTH_W'(1),
                                                '0, 1'b0, b));
            end
         end
         if (cls == CLASS_DIGIT) begin
            grown = number_acc * 10 + (b - CHAR_ZERO);
            if (grown > VALUE_MAX) begin
               number_acc = VALUE_MAX;
               number_ovf = 1'b1;
            end else begin
               number_acc = grown[VALUE_W-1:0];
            end
         end
         byte_pos = byte_pos + 1'b1;
      end
      if (item_tokens.size() > 0) begin
         tail      = item_tokens.pop_back();
         tail.last = 1'b1;
         item_tokens.push_back(tail);
      end
      foreach (item_tokens[i])
         expected_tokens.push_back(item_tokens[i]);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("token %0d %s got %0h expected %0h",
                                   tokens_checked, name, got, want));
   endtask

   task automatic check_token();
      token_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("token %0d unexpected, kind %0d start %0h",
                                   tokens_checked, rsp_token_kind, rsp_start_position));
      end else begin
         want = expected_tokens.pop_front();
         check_field("kind", 32'(rsp_token_kind), 32'(want.kind));
         check_field("start", 32'(rsp_start_position), 32'(want.start));
         check_field("length", 32'(rsp_token_length), 32'(want.length));
         check_field("value", 32'(rsp_number_value), 32'(want.value));
         check_field("overflow", 32'(rsp_value_overflow), 32'(want.overflow));
         check_field("char", 32'(rsp_token_char), 32'(want.ch));
         check_field("last", 32'(rsp_last_of_run), 32'(want.last));
      end
      tokens_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_class  = CLASS_NONE;
         run_start  = '0;
         run_length = '0;
         number_acc = '0;
         number_ovf = 1'b0;
         byte_pos   = '0;
         expected_tokens.delete();
      end else begin
         // predict the accepted byte's tokens first, then check any token taken at this edge
         if (req_valid && req_ready)
            tokenize_item(req_type, req_text_byte);
         if (rsp_valid && rsp_ready)
            check_token();
      end
      queued = expected_tokens.size();
   end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: clock, reset, byte stimulus in idle phases, and the verdict.
`timescale 1ns / 1ps

module tb
   import aet_pkg::*;
;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_type      = 1'b0;
   logic [CHAR_W-1:0]     req_text_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [KIND_WIDTH-1:0] rsp_token_kind;
   logic [OUT_POS_W-1:0]  rsp_start_position;
   logic [LENGTH_W-1:0]   rsp_token_length;
   logic [VALUE_W-1:0]    rsp_number_value;
   logic                  rsp_value_overflow;
   logic [CHAR_W-1:0]     rsp_token_char;
   logic                  rsp_last_of_run;

   int fail_count;
   int pending;
   int send_idle_pct = 27;
   int recv_idle_pct = 66;
   int items_sent    = 0;

   arith_expression_tokenizer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_start_position (rsp_start_position),
      .rsp_token_length   (rsp_token_length),
      .rsp_number_value   (rsp_number_value),
      .rsp_value_overflow (rsp_value_overflow),
      .rsp_token_char     (rsp_token_char),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   aet_token_checker token_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_start_position (rsp_start_position),
      .rsp_token_length   (rsp_token_length),
      .rsp_number_value   (rsp_number_value),
      .rsp_value_overflow (rsp_value_overflow),
      .rsp_token_char     (rsp_token_char),
      .rsp_last_of_run    (rsp_last_of_run),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #1_500_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic logic [CHAR_W-1:0] space_byte();
      if ($urandom_range(5) == 0)
         return CHAR_SPACE;
      return CHAR_TAB + CHAR_W'($urandom_range(4));
   endfunction

   function automatic logic [CHAR_W-1:0] digit_byte();
      return CHAR_ZERO + CHAR_W'($urandom_range(9));
   endfunction

   // Returns right after the edge that accepted the item.
   task automatic send_item(input logic is_end, input logic [CHAR_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= is_end;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Mostly expression-shaped text, with stray bytes and text ends mixed in.
   task automatic send_random(input int count);
      int                stop_at;
      int                pick;
      int                len;
      logic [CHAR_W-1:0] b;
      string             prefix;
      stop_at = items_sent + count;
      prefix  = "214748364";
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            if ($urandom_range(15) == 0) begin
               // lands right around the saturation point
               for (int k = 0; k < prefix.len(); k++)
                  send_item(1'b0, prefix[k]);
               send_item(1'b0, digit_byte());
            end else begin
               len = ($urandom_range(7) == 0) ? $urandom_range(12, 9) : $urandom_range(4, 1);
               repeat (len) send_item(1'b0, digit_byte());
            end
         end else if (pick < 60) begin
            repeat ($urandom_range(3, 1)) send_item(1'b0, space_byte());
         end else if (pick < 85) begin
            case ($urandom_range(5))
               0:       b = CHAR_PLUS;
               1:       b = CHAR_MINUS;
               2:       b = CHAR_STAR;
               3:       b = CHAR_SLASH;
               4:       b = CHAR_OPEN;
               default: b = CHAR_CLOSE;
            endcase
            send_item(1'b0, b);
         end else if (pick < 93) begin
            send_item(1'b0, CHAR_W'($urandom()));
         end else begin
            send_item(1'b1, CHAR_W'($urandom()));
         end
      end
   endtask

   initial begin
      string text;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // leading zero, every operator, numbers closed by operators
      text = "07*(1)+-/";
      for (int k = 0; k < text.len(); k++)
         send_item(1'b0, text[k]);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'hA5);   // end with no open run
      for (int c = CHAR_TAB; c <= CHAR_CR; c++)
         send_item(1'b0, c[CHAR_W-1:0]);
      send_item(1'b0, CHAR_SPACE);
      send_item(1'b1, 8'h00);   // closes the whitespace run
      send_item(1'b1, 8'hFF);   // empty text
      send_random(370);

      send_idle_pct = 66;
      recv_idle_pct = 27;
      send_random(370);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_item(1'b0, CHAR_PLUS);
      send_item(1'b1, 8'h00);
      send_random(370);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
